// ===== rtl/hvn_pkg.sv =====
`default_nettype none
package hvn_pkg;

  localparam int CoordFracBits = 16;
  localparam int IntW = 32 - CoordFracBits;
  localparam int PrimeW = 27;
  localparam int ProdW = 32 + PrimeW;
  localparam int NumAxes = 3;
  localparam int NumCorners = 8;

  localparam logic [63:0] GoldenInc = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MixMulA = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MixMulB = 64'h94D049BB133111EB;
  localparam logic [PrimeW-1:0] PrimeX = 27'd73856093;
  localparam logic [PrimeW-1:0] PrimeY = 27'd19349663;
  localparam logic [PrimeW-1:0] PrimeZ = 27'd83492791;
  localparam logic [17:0] SmoothK = 18'd196608;

  typedef logic [1:0] dims_t;
  localparam dims_t Dim2 = 2'd2;
  localparam dims_t Dim3 = 2'd3;
  localparam dims_t DimReset = 2'd3;

  typedef logic [15:0] frac_t;
  typedef logic signed [16:0] samp_t;

  typedef struct packed {
    frac_t u;
    frac_t v;
    frac_t w;
  } wgt_t;

  function automatic samp_t lerp16(samp_t a, samp_t b, frac_t s);
    logic signed [17:0] d;
    logic signed [34:0] p;
    logic signed [18:0] q;
    d = 18'(b) - 18'(a);
    p = $signed({1'b0, s}) * d;
    q = 19'(p >>> 16);
    return samp_t'(a + 17'(q));
  endfunction

endpackage
`default_nettype wire

// ===== rtl/hashed_value_noise_generator.sv =====
// Throughput: one point per cycle while the output is not stalled; a single enable moves all nine register stages,
// set by the output register being empty or taken in the same cycle.
// Reset clears the stage valid bits and sets the dimension register to 3D;
// the data registers are not reset.
`default_nettype none
module hashed_value_noise_generator (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [31:0]  in_coord_x,
  input  wire logic signed [31:0]  in_coord_y,
  input  wire logic signed [31:0]  in_coord_z,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [16:0]       out_noise_value,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_dimensions
);
  import hvn_pkg::*;

  localparam int NumStages = 9;
  localparam int WgtDelay = 4;

  logic                 en;
  logic [NumStages-1:0] vld_r, vld_nxt;
  dims_t                dims_r;
  logic [63:0]          seed [NumCorners];
  samp_t                corner [NumCorners];
  wgt_t                 wgt_front;
  wgt_t                 wgt_r [WgtDelay];
  samp_t                noise;

  assign en = !vld_r[NumStages-1] || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;
  assign vld_nxt = {vld_r[NumStages-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      dims_r <= DimReset;
    end else begin
      if (en) begin
        vld_r <= vld_nxt;
      end
      if (cfg_valid) begin
        dims_r <= cfg_dimensions;
      end
    end
  end

  hvn_front u_front (
    .clk     (clk),
    .en      (en),
    .coord_x (in_coord_x),
    .coord_y (in_coord_y),
    .coord_z (in_coord_z),
    .dims    (dims_r),
    .seed_o  (seed),
    .wgt_o   (wgt_front)
  );

  for (genvar k = 0; k < NumCorners; k++) begin : g_hash
    hvn_hash u_hash (
      .clk      (clk),
      .en       (en),
      .z_i      (seed[k]),
      .corner_o (corner[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      wgt_r[0] <= wgt_front;
      for (int i = 1; i < WgtDelay; i++) begin
        wgt_r[i] <= wgt_r[i-1];
      end
    end
  end

  hvn_blend u_blend (
    .clk      (clk),
    .en       (en),
    .corner_i (corner),
    .wgt_i    (wgt_r[WgtDelay-1]),
    .noise_o  (noise)
  );

  assign out_valid = vld_r[NumStages-1];
  assign out_noise_value = noise;

endmodule
`default_nettype wire

// ===== rtl/hvn_front.sv =====
`default_nettype none
module hvn_front (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [31:0]          coord_x,
  input  wire logic [31:0]          coord_y,
  input  wire logic [31:0]          coord_z,
  input  wire hvn_pkg::dims_t       dims,
  output logic [63:0]               seed_o [hvn_pkg::NumCorners],
  output hvn_pkg::wgt_t             wgt_o
);
  import hvn_pkg::*;

  logic [31:0]              crd [NumAxes];
  logic [PrimeW-1:0]        prime [NumAxes];
  logic signed [IntW-1:0]   ip_r [NumAxes];
  logic signed [IntW-1:0]   ip_nxt [NumAxes];
  frac_t                    t_r [NumAxes];
  frac_t                    t_nxt [NumAxes];
  logic [31:0]              tsq_r [NumAxes];
  logic [31:0]              tsq_nxt [NumAxes];
  logic [ProdW-1:0]         prod_r [NumAxes][2];
  logic [ProdW-1:0]         prod_nxt [NumAxes][2];
  dims_t                    dims_r;
  logic [63:0]              z_r [NumCorners];
  logic [63:0]              z_nxt [NumCorners];
  frac_t                    s_r [NumAxes];
  frac_t                    s_nxt [NumAxes];

  assign crd[0] = coord_x;
  assign crd[1] = coord_y;
  assign crd[2] = coord_z;
  assign prime[0] = PrimeX;
  assign prime[1] = PrimeY;
  assign prime[2] = PrimeZ;

  always_comb begin
    logic signed [IntW:0] ip1;
    logic [47:0] fr;
    for (int a = 0; a < NumAxes; a++) begin
      ip_nxt[a] = $signed(crd[a][31:CoordFracBits]);
      ip1 = (IntW+1)'(ip_nxt[a]) + (IntW+1)'(1);
      fr = 48'(crd[a][CoordFracBits-1:0]) << 16;
      t_nxt[a] = 16'(fr >> CoordFracBits);
      tsq_nxt[a] = 32'(t_nxt[a]) * 32'(t_nxt[a]);
      prod_nxt[a][0] = ProdW'($unsigned(32'(ip_nxt[a]))) * ProdW'(prime[a]);
      prod_nxt[a][1] = ProdW'($unsigned(32'(ip1))) * ProdW'(prime[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ip_r <= ip_nxt;
      t_r <= t_nxt;
      tsq_r <= tsq_nxt;
      prod_r <= prod_nxt;
      dims_r <= dims;
    end
  end

  always_comb begin
    logic [49:0] sp;
    logic signed [IntW:0] ipe [NumAxes][2];
    logic [63:0] seed;
    logic xb, yb, zb;
    for (int a = 0; a < NumAxes; a++) begin
      sp = 50'(tsq_r[a]) * 50'(SmoothK - {1'b0, t_r[a], 1'b0});
      s_nxt[a] = 16'(sp >> 32);
      ipe[a][0] = (IntW+1)'(ip_r[a]);
      ipe[a][1] = (IntW+1)'(ip_r[a]) + (IntW+1)'(1);
    end
    for (int k = 0; k < NumCorners; k++) begin
      xb = 1'((k >> 0) & 1);
      yb = 1'((k >> 1) & 1);
      zb = 1'((k >> 2) & 1);
      case (dims_r)
        Dim3: begin
          seed = 64'(prod_r[0][xb]) ^ 64'(prod_r[1][yb]) ^ 64'(prod_r[2][zb]);
        end
        Dim2: begin
          seed = {32'(ipe[1][yb]), 32'(ipe[0][xb])};
        end
        default: begin
          seed = 64'(ipe[0][xb]);
        end
      endcase
      z_nxt[k] = seed + GoldenInc;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      z_r <= z_nxt;
      s_r <= s_nxt;
    end
  end

  assign seed_o = z_r;
  assign wgt_o = '{u: s_r[0], v: s_r[1], w: s_r[2]};

endmodule
`default_nettype wire

// ===== rtl/hvn_hash.sv =====
`default_nettype none
module hvn_hash (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [63:0]   z_i,
  output hvn_pkg::samp_t     corner_o
);
  import hvn_pkg::*;

  logic [63:0] pa0_r, pa0_nxt;
  logic [31:0] pa1_r, pa1_nxt, pa2_r, pa2_nxt;
  logic [63:0] z2_r, z2_nxt;
  logic [63:0] pb0_r, pb0_nxt;
  logic [31:0] pb1_r, pb1_nxt, pb2_r, pb2_nxt;
  samp_t       corner_r, corner_nxt;
  logic [63:0] m1, m2, z3;

  always_comb begin
    m1 = z_i ^ (z_i >> 30);
    pa0_nxt = 64'(m1[31:0]) * 64'(MixMulA[31:0]);
    pa1_nxt = 32'(m1[63:32] * MixMulA[31:0]);
    pa2_nxt = 32'(m1[31:0] * MixMulA[63:32]);
    z2_nxt = pa0_r + {32'(pa1_r + pa2_r), 32'd0};
    m2 = z2_r ^ (z2_r >> 27);
    pb0_nxt = 64'(m2[31:0]) * 64'(MixMulB[31:0]);
    pb1_nxt = 32'(m2[63:32] * MixMulB[31:0]);
    pb2_nxt = 32'(m2[31:0] * MixMulB[63:32]);
    z3 = pb0_r + {32'(pb1_r + pb2_r), 32'd0};
    corner_nxt = $signed({~z3[63], z3[62:47]});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pa0_r <= pa0_nxt;
      pa1_r <= pa1_nxt;
      pa2_r <= pa2_nxt;
      z2_r <= z2_nxt;
      pb0_r <= pb0_nxt;
      pb1_r <= pb1_nxt;
      pb2_r <= pb2_nxt;
      corner_r <= corner_nxt;
    end
  end

  assign corner_o = corner_r;

endmodule
`default_nettype wire

// ===== rtl/hvn_blend.sv =====
`default_nettype none
module hvn_blend (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire hvn_pkg::samp_t corner_i [hvn_pkg::NumCorners],
  input  wire hvn_pkg::wgt_t  wgt_i,
  output hvn_pkg::samp_t      noise_o
);
  import hvn_pkg::*;

  samp_t l1_r [4];
  samp_t l1_nxt [4];
  samp_t l2_r [2];
  samp_t l2_nxt [2];
  samp_t res_r, res_nxt;
  frac_t v1_r, w1_r, w2_r;

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      l1_nxt[j] = lerp16(corner_i[2*j], corner_i[2*j+1], wgt_i.u);
    end
    for (int m = 0; m < 2; m++) begin
      l2_nxt[m] = lerp16(l1_r[2*m], l1_r[2*m+1], v1_r);
    end
    res_nxt = lerp16(l2_r[0], l2_r[1], w2_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      l1_r <= l1_nxt;
      v1_r <= wgt_i.v;
      w1_r <= wgt_i.w;
      l2_r <= l2_nxt;
      w2_r <= w1_r;
      res_r <= res_nxt;
    end
  end

  assign noise_o = res_r;

endmodule
`default_nettype wire

// ===== rtl/hvn_checker.sv =====
`default_nettype none
module hvn_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [16:0] out_noise_value
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_noise_value))
    else $error("Result transaction changed while stalled.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("Input stalled while the output side could move.");

  a_free_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("Input not ready with an empty output register.");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result presented right after reset.");

endmodule

bind hashed_value_noise_generator hvn_checker u_hvn_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_noise_value (out_noise_value)
);
`default_nettype wire
